[rtl/can_pgn_message_aggregator_core_defines.svh]
// Assertion macros shared by the aggregator modules.
`ifndef CAN_PGN_MESSAGE_AGGREGATOR_CORE_DEFINES_SVH
`define CAN_PGN_MESSAGE_AGGREGATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpma assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpma assertion failed");

`endif

[rtl/cpma_pkg.sv]
// Types and constants of the CAN PGN message aggregator.
package cpma_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int SLOT_W    = 6;

  localparam logic       OP_FRAME     = 1'b0;
  localparam logic       OP_READ      = 1'b1;
  localparam logic [3:0] PGN_CLASS    = 4'hA;
  localparam logic [15:0] PGN_EXCLUDED = 16'hAF00;
  localparam logic [3:0] PGN_XLAT_HI  = 4'hF;

  typedef struct packed {
    logic        opcode;
    logic [28:0] can_id;
    logic [63:0] payload;
    logic [7:0]  entry_index;
  } cpma_in_t;

  typedef struct packed {
    logic        accepted;
    logic        was_update;
    logic [3:0]  stored_slot;
    logic        entry_valid;
    logic [15:0] entry_pgn;
    logic [7:0]  entry_source;
    logic [63:0] entry_payload;
    logic [4:0]  valid_count;
    logic [15:0] received_count;
    logic [15:0] processed_count;
    logic [28:0] last_id;
  } cpma_out_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              has_empty;
    logic [SLOT_W-1:0] empty_slot;
  } cpma_lookup_t;

endpackage

[rtl/can_pgn_message_aggregator_core.sv]
// Top level of the CAN PGN message aggregator: control, counters and result register.
// A word is looked up in ST_LOOK, where the tag store and payload RAM are written and
// read, and its result word is loaded into the result register in ST_RESP once the
// output is free; the next word is accepted only in ST_IDLE or in ST_RESP as it loads.
// Reset clears all valid bits, the counters and the control state at once; the
// payload RAM is not cleared because empty slots are never read out.
`include "can_pgn_message_aggregator_core_defines.svh"

module can_pgn_message_aggregator_core import cpma_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cpma_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cpma_out_t out_word_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [7:0] IDX_LIMIT = 8'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RESP
  } state_e;

  state_e       state_q;
  cpma_in_t     item_q;
  logic         out_valid_q;
  cpma_out_t    out_word_q;
  logic [15:0]  rx_cnt_q;
  logic [15:0]  proc_cnt_q;
  logic [28:0]  last_id_q;
  logic         r_acc_q;
  logic         r_upd_q;
  logic [3:0]   r_slot_q;
  logic         r_ev_q;
  logic [11:0]  r_pgn_q;
  logic [7:0]   r_src_q;

  logic [15:0]  pgn;
  logic [11:0]  pgn_low;
  logic [7:0]   src;
  logic         pass;
  logic         look;
  logic         in_range;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_slot;
  logic         out_free;
  logic         in_accept;
  cpma_lookup_t lookup;
  logic         t_valid;
  logic [11:0]  t_pgn_low;
  logic [7:0]   t_src;
  logic [CW-1:0] cnt;
  logic [63:0]  rd_data;
  cpma_out_t    out_word_d;

  assign look     = (state_q == ST_LOOK);
  assign pgn      = item_q.can_id[23:8];
  assign pgn_low  = pgn[11:0];
  assign src      = item_q.can_id[7:0];
  assign pass     = look && (item_q.opcode == OP_FRAME) && (pgn[15:12] == PGN_CLASS) &&
                    (pgn != PGN_EXCLUDED);
  assign in_range = (item_q.entry_index < IDX_LIMIT);
  assign rd_idx   = in_range ? item_q.entry_index[AW-1:0] : '0;

  always_comb begin
    if (lookup.hit) begin
      wr_slot = AW'(lookup.hit_slot);
    end else if (lookup.has_empty) begin
      wr_slot = AW'(lookup.empty_slot);
    end else begin
      wr_slot = '0;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;

  cpma_tag_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_tags (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .look_pgn_low_i (pgn_low),
    .look_src_i     (src),
    .wr_en_i        (pass),
    .wr_slot_i      (wr_slot),
    .rd_idx_i       (rd_idx),
    .lookup_o       (lookup),
    .rd_valid_o     (t_valid),
    .rd_pgn_low_o   (t_pgn_low),
    .rd_src_o       (t_src),
    .count_o        (cnt)
  );

  cpma_data_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (pass),
    .waddr_i (wr_slot),
    .wdata_i (item_q.payload),
    .re_i    (look),
    .raddr_i (rd_idx),
    .rdata_o (rd_data)
  );

  always_comb begin
    out_word_d                 = '0;
    out_word_d.accepted        = r_acc_q;
    out_word_d.was_update      = r_upd_q;
    out_word_d.stored_slot     = r_slot_q;
    out_word_d.entry_valid     = r_ev_q;
    out_word_d.valid_count     = 5'(cnt);
    out_word_d.received_count  = rx_cnt_q;
    out_word_d.processed_count = proc_cnt_q;
    out_word_d.last_id         = last_id_q;
    if (r_ev_q) begin
      out_word_d.entry_pgn     = {PGN_XLAT_HI, r_pgn_q};
      out_word_d.entry_source  = r_src_q;
      out_word_d.entry_payload = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      rx_cnt_q    <= '0;
      proc_cnt_q  <= '0;
      last_id_q   <= '0;
      r_acc_q     <= 1'b0;
      r_upd_q     <= 1'b0;
      r_slot_q    <= '0;
      r_ev_q      <= 1'b0;
      r_pgn_q     <= '0;
      r_src_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        item_q <= in_word_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          r_acc_q  <= pass;
          r_upd_q  <= pass && lookup.hit;
          r_slot_q <= pass ? 4'(wr_slot) : 4'd0;
          r_ev_q   <= (item_q.opcode == OP_READ) && in_range && t_valid;
          r_pgn_q  <= t_pgn_low;
          r_src_q  <= t_src;
          if (pass) begin
            rx_cnt_q   <= rx_cnt_q + 16'd1;
            proc_cnt_q <= proc_cnt_q + 16'd1;
            last_id_q  <= item_q.can_id;
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= out_word_d;
            state_q     <= in_accept ? ST_LOOK : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `CPMA_ASSERT_NEXT(a_accept_to_look, in_accept, state_q == ST_LOOK)
  `CPMA_ASSERT_NOW(a_look_stalls, state_q == ST_LOOK, in_stall_o)
  `CPMA_ASSERT_NOW(a_result_from_resp, $rose(out_valid_q), $past(state_q == ST_RESP))

endmodule

[rtl/cpma_tag_store.sv]
// Slot tags and valid bits with parallel match and free-slot search.
`include "can_pgn_message_aggregator_core_defines.svh"

module cpma_tag_store import cpma_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [11:0]   look_pgn_low_i,
  input  logic [7:0]    look_src_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_slot_i,
  input  logic [AW-1:0] rd_idx_i,
  output cpma_lookup_t  lookup_o,
  output logic          rd_valid_o,
  output logic [11:0]   rd_pgn_low_o,
  output logic [7:0]    rd_src_o,
  output logic [CW-1:0] count_o
);

  logic [DEPTH-1:0] valid_q;
  logic [11:0]      pgn_q [DEPTH];
  logic [7:0]       src_q [DEPTH];
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    cnt_d;
  logic [DEPTH-1:0] match;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = valid_q[i] && (pgn_q[i] == look_pgn_low_i) && (src_q[i] == look_src_i);
    end
  end

  always_comb begin
    lookup_o = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_o.hit      = 1'b1;
        lookup_o.hit_slot = SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        lookup_o.has_empty  = 1'b1;
        lookup_o.empty_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_valid_o   = valid_q[rd_idx_i];
  assign rd_pgn_low_o = pgn_q[rd_idx_i];
  assign rd_src_o     = src_q[rd_idx_i];
  assign count_o      = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !valid_q[wr_slot_i]) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pgn_q[wr_slot_i] <= look_pgn_low_i;
      src_q[wr_slot_i] <= look_src_i;
    end
  end

  `CPMA_ASSERT_NOW(a_match_unique, 1'b1, $onehot0(match))
  `CPMA_ASSERT_NOW(a_count_tracks, 1'b1, cnt_q == CW'($countones(valid_q)))
  `CPMA_ASSERT_NEXT(a_write_sets_valid, wr_en_i, valid_q[$past(wr_slot_i)])

endmodule

[rtl/cpma_data_ram.sv]
// Payload memory with one write port and one registered read port.
module cpma_data_ram import cpma_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the CAN PGN message aggregator core.
module tb_top;
  import cpma_pkg::*;

  localparam int TBL_DEPTH   = DEPTH_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int RAND_WORDS  = 1100;
  localparam int CALM_TAIL   = 150;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    cpma_in_t word;
    bit       settle;
    bit       quiet;
  } request_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  cpma_in_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  cpma_out_t out_word_o;

  request_t  request_q[$];
  cpma_out_t aggr_result_q[$];
  cpma_out_t want;

  logic        slot_used[TBL_DEPTH];
  logic [11:0] slot_pgn[TBL_DEPTH];
  logic [7:0]  slot_src[TBL_DEPTH];
  logic [63:0] slot_bytes[TBL_DEPTH];
  logic [15:0] rx_total;
  logic [15:0] stored_total;
  logic [28:0] last_ident;

  logic [11:0] key_pgn[POOL_SIZE];
  logic [7:0]  key_src[POOL_SIZE];

  bit quiet_now = 1'b0;
  int gap_left;
  int stall_left;
  int cycle_count;
  int mismatches;
  int words_sent;
  int results_seen;
  int frames_stored;
  int slot_updates;
  int full_evictions;
  int read_hits;

  can_pgn_message_aggregator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic cpma_out_t aggregate_word(cpma_in_t w);
    cpma_out_t   r;
    logic [15:0] pgn;
    logic [7:0]  src;
    int          hit;
    int          slot;
    int          n;
    r = '0;
    pgn = w.can_id[23:8];
    src = w.can_id[7:0];
    if (w.opcode == OP_FRAME) begin
      if (pgn[15:12] == PGN_CLASS && pgn != PGN_EXCLUDED) begin
        rx_total = rx_total + 16'd1;
        last_ident = w.can_id;
        hit = -1;
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (hit < 0 && slot_used[i] && slot_pgn[i] == pgn[11:0] && slot_src[i] == src) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          slot = hit;
          r.was_update = 1'b1;
          slot_updates++;
        end else begin
          slot = -1;
          for (int i = 0; i < TBL_DEPTH; i++) begin
            if (slot < 0 && !slot_used[i]) begin
              slot = i;
            end
          end
          if (slot < 0) begin
            slot = 0;
            full_evictions++;
          end
          slot_pgn[slot] = pgn[11:0];
          slot_src[slot] = src;
          slot_used[slot] = 1'b1;
        end
        slot_bytes[slot] = w.payload;
        stored_total = stored_total + 16'd1;
        frames_stored++;
        r.accepted = 1'b1;
        r.stored_slot = slot[3:0];
      end
    end else if (w.entry_index < TBL_DEPTH && slot_used[w.entry_index]) begin
      r.entry_valid = 1'b1;
      r.entry_pgn = {PGN_XLAT_HI, slot_pgn[w.entry_index]};
      r.entry_source = slot_src[w.entry_index];
      r.entry_payload = slot_bytes[w.entry_index];
      read_hits++;
    end
    n = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (slot_used[i]) begin
        n++;
      end
    end
    r.valid_count = n[4:0];
    r.received_count = rx_total;
    r.processed_count = stored_total;
    r.last_id = last_ident;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatches++;
    $display("mismatch in %s: got %h, wanted %h (cycle %0d)", what, got, exp_val,
             cycle_count);
  endtask

  task automatic push_frame(input logic [28:0] id, input logic [63:0] data, input bit quiet);
    request_t rq;
    rq.word.opcode = OP_FRAME;
    rq.word.can_id = id;
    rq.word.payload = data;
    rq.word.entry_index = 8'($urandom);
    rq.settle = 1'b0;
    rq.quiet = quiet;
    request_q.push_back(rq);
  endtask

  task automatic push_read(input logic [7:0] idx, input bit quiet);
    request_t rq;
    rq.word.opcode = OP_READ;
    rq.word.can_id = 29'($urandom);
    rq.word.payload = {$urandom, $urandom};
    rq.word.entry_index = idx;
    rq.settle = 1'b0;
    rq.quiet = quiet;
    request_q.push_back(rq);
  endtask

  task automatic push_random(input bit quiet);
    int          sel;
    int          k;
    logic [63:0] data;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_SIZE - 1);
    data = {$urandom, $urandom};
    if (sel < 55) begin
      push_frame({5'($urandom), PGN_CLASS, key_pgn[k], key_src[k]}, data, quiet);
    end else if (sel < 65) begin
      push_frame({5'($urandom), PGN_CLASS, 12'($urandom), 8'($urandom)}, data, quiet);
    end else if (sel < 72) begin
      push_frame(29'($urandom), data, quiet);
    end else if (sel < 75) begin
      push_frame({5'($urandom), PGN_EXCLUDED, 8'($urandom)}, data, quiet);
    end else if ($urandom_range(0, 3) == 0) begin
      push_read(8'($urandom), quiet);
    end else begin
      push_read(8'($urandom_range(0, TBL_DEPTH - 1)), quiet);
    end
  endtask

  // Sender: presents queued words and keeps the model in step with acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      quiet_now <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        aggr_result_q.push_back(aggregate_word(in_word_i));
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (request_q[0].settle && aggr_result_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (!request_q[0].quiet && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else begin
          in_word_i <= request_q[0].word;
          quiet_now <= request_q[0].quiet;
          request_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each accepted result word and stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (aggr_result_q.size() == 0) begin
          report_mismatch("unexpected result word", 64'(out_word_o.last_id), '0);
        end else begin
          want = aggr_result_q.pop_front();
          if (out_word_o.accepted !== want.accepted)
            report_mismatch("accepted", 64'(out_word_o.accepted), 64'(want.accepted));
          if (out_word_o.was_update !== want.was_update)
            report_mismatch("was_update", 64'(out_word_o.was_update),
                            64'(want.was_update));
          if (out_word_o.stored_slot !== want.stored_slot)
            report_mismatch("stored_slot", 64'(out_word_o.stored_slot),
                            64'(want.stored_slot));
          if (out_word_o.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 64'(out_word_o.entry_valid),
                            64'(want.entry_valid));
          if (out_word_o.entry_pgn !== want.entry_pgn)
            report_mismatch("entry_pgn", 64'(out_word_o.entry_pgn), 64'(want.entry_pgn));
          if (out_word_o.entry_source !== want.entry_source)
            report_mismatch("entry_source", 64'(out_word_o.entry_source),
                            64'(want.entry_source));
          if (out_word_o.entry_payload !== want.entry_payload)
            report_mismatch("entry_payload", out_word_o.entry_payload, want.entry_payload);
          if (out_word_o.valid_count !== want.valid_count)
            report_mismatch("valid_count", 64'(out_word_o.valid_count),
                            64'(want.valid_count));
          if (out_word_o.received_count !== want.received_count)
            report_mismatch("received_count", 64'(out_word_o.received_count),
                            64'(want.received_count));
          if (out_word_o.processed_count !== want.processed_count)
            report_mismatch("processed_count", 64'(out_word_o.processed_count),
                            64'(want.processed_count));
          if (out_word_o.last_id !== want.last_id)
            report_mismatch("last_id", 64'(out_word_o.last_id), 64'(want.last_id));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_now && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    request_t rq;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_pgn[i] = '0;
      slot_src[i] = '0;
      slot_bytes[i] = '0;
    end
    rx_total = '0;
    stored_total = '0;
    last_ident = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pgn[i] = 12'($urandom);
      key_src[i] = 8'($urandom);
    end

    // Directed: empty and out-of-range reads, filter edges, update, fill and eviction.
    push_read(8'd0, 1'b0);
    push_read(8'hFF, 1'b0);
    push_frame(29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_frame({5'h00, PGN_EXCLUDED, 8'h12}, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_frame({5'h00, 16'hA000, 8'h00}, 64'h0, 1'b0);
    push_frame({5'h1F, 16'hAFFF, 8'hFF}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_frame({5'h0A, 16'hA000, 8'h00}, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);
    push_frame({5'h15, 16'hAF01, 8'h80}, {$urandom, $urandom}, 1'b0);
    push_read(8'd1, 1'b0);
    push_read(8'(TBL_DEPTH), 1'b0);
    push_read(8'(TBL_DEPTH - 1), 1'b0);
    for (int k = 0; k < TBL_DEPTH - 3; k++) begin
      push_frame({5'($urandom), PGN_CLASS, 12'(12'h100 + k), 8'(k * 17)},
                 {$urandom, $urandom}, 1'b0);
    end
    push_frame({5'h00, 16'hA555, 8'h55}, {$urandom, $urandom}, 1'b0);
    push_read(8'd0, 1'b0);

    for (int k = 0; k < RAND_WORDS - CALM_TAIL; k++) begin
      push_random(1'b0);
      if (k == (RAND_WORDS - CALM_TAIL) / 2) begin
        rq = request_q.pop_back();
        rq.settle = 1'b1;
        request_q.push_back(rq);
      end
    end

    for (int k = 0; k < CALM_TAIL; k++) begin
      push_random(1'b1);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i || aggr_result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("run covered %0d words and %0d result words: %0d frames stored, %0d in place,",
             words_sent, results_seen, frames_stored, slot_updates);
    $display("%0d evictions of slot 0 on a full table, %0d reads of valid slots",
             full_evictions, read_hits);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cpma_pkg.sv
rtl/cpma_tag_store.sv
rtl/cpma_data_ram.sv
rtl/can_pgn_message_aggregator_core.sv
verif/tb_top.sv
